// ----- src/sbff_pkg.sv -----
// Package for the sprite bank first-fit allocator.
// Holds item structs, status and register codes, and the control state type.
// No dependencies.
package sbff_pkg;

	localparam int HB_W = 9;
	localparam int CB_W = 12;
	localparam int OFS_W = 14;
	localparam int CFG_IDX_W = 2;

	typedef struct packed {
		logic       req_type;
		logic [7:0] info_byte;
	} sbff_in_t;

	typedef struct packed {
		logic [1:0]       status;
		logic [4:0]       bank_index;
		logic [OFS_W-1:0] header_offset;
		logic [HB_W-1:0]  header_bytes;
		logic [CB_W-1:0]  char_bytes;
		logic [6:0]       pointer_high;
		logic [7:0]       rom_bank;
	} sbff_out_t;

	typedef enum logic [1:0] {
		STAT_PLACED     = 2'd0,
		STAT_FULL       = 2'd1,
		STAT_TOO_LARGE  = 2'd2,
		STAT_START_DONE = 2'd3
	} status_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BANK0_START = 2'd0,
		CFG_BANK0_RSVD  = 2'd1,
		CFG_FIRST_ROM   = 2'd2
	} cfg_reg_t;

	typedef enum logic [0:0] {
		REQ_START    = 1'b0,
		REQ_ALLOCATE = 1'b1
	} req_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_RESP
	} state_t;

endpackage

// ----- src/sbff_bank_ram.sv -----
// Bank state memory: one entry per bank, header position and character fill.
// One write port, one read port with registered read data. Uses sbff_pkg.
module sbff_bank_ram import sbff_pkg::*; #(
	parameter int DEPTH = 32,
	parameter int AW = 5,
	parameter int DW = 30
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/sbff_fit.sv -----
// Fit check for one bank: aligned header end plus both character regions.
// Combinational; uses sbff_pkg for the item field widths.
module sbff_fit import sbff_pkg::*; #(
	parameter int PW = 15,
	parameter int CW = 15,
	parameter int SW = 17,
	parameter int BANK_BYTES = 16384,
	parameter int ALIGN_MASK = 31
) (
	input  logic [PW-1:0]   hpos,
	input  logic [CW-1:0]   cfill,
	input  logic [HB_W-1:0] header_bytes,
	input  logic [CB_W-1:0] char_bytes,
	output logic            fit
);

	logic [SW-1:0] hraw;
	logic [SW-1:0] hend;
	logic [SW-1:0] total;

	always_comb begin
		hraw  = SW'(hpos) + SW'(header_bytes) + SW'(ALIGN_MASK);
		hend  = hraw & ~SW'(ALIGN_MASK);
		total = hend + SW'(cfill) + SW'(char_bytes);
		fit   = (total <= SW'(BANK_BYTES));
	end

endmodule

// ----- src/sprite_bank_first_fit_allocator_top.sv -----
// Sprite bank first-fit allocator, top level.
// A start item writes its result straight into the result register; an allocate item
// scans the open banks in order, one open bank checked per cycle through the read port
// of the bank memory. One item in flight; the next is taken the cycle after the result
// has moved to the output register. Reset clears control state and the configuration
// registers; bank memory and the result and output data registers are not cleared.
module sprite_bank_first_fit_allocator_top import sbff_pkg::*; #(
	parameter int BANK_BYTES = 16384,
	parameter int BANK_COUNT = 32,
	parameter int ALIGN_MASK = 31
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  sbff_in_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output sbff_out_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [OFS_W-1:0]     cfg_data
);

	localparam int CW = $clog2(BANK_BYTES + 1);
	localparam int PW = (CW > 15) ? CW : 15;
	localparam int SW = PW + 2;
	localparam int AW = (BANK_COUNT > 1) ? $clog2(BANK_COUNT) : 1;
	localparam int OW = $clog2(BANK_COUNT + 1);
	localparam int JW = (AW > 8) ? AW : 8;
	localparam int DW = PW + CW;

	state_t state_q, state_d;

	logic [OFS_W-1:0] start_ofs_q;
	logic [OFS_W-1:0] rsvd_q;
	logic [7:0]       first_rom_q;

	logic [OW-1:0]   banks_open_q;
	logic [OW-1:0]   rd_idx_q;
	logic [HB_W-1:0] hbytes_q;
	logic [CB_W-1:0] cbytes_q;
	logic            chk_vld_s1;
	logic [AW-1:0]   chk_idx_s1;
	sbff_out_t       res_q;
	sbff_out_t       out_data_q;
	logic            out_valid_q;

	logic [6:0]      pieces;
	logic [HB_W-1:0] hbytes_in;
	logic [CB_W-1:0] cbytes_in;

	logic          out_free;
	logic          rd_avail;
	logic          bank_fit;
	logic          empty_fit;
	logic          found;
	logic          exhaust;
	logic          table_full;
	logic          new_ok;
	logic          start_acc;
	logic          alloc_acc;
	logic          rd_en;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [DW-1:0] ram_wdata;
	logic [DW-1:0] ram_rdata;
	logic [PW-1:0] rd_hpos;
	logic [CW-1:0] rd_cfill;
	logic [PW-1:0] sel_hpos;
	logic [CW-1:0] sel_cfill;
	logic [AW-1:0] sel_j;
	logic [JW-1:0] j_ext;
	logic [PW-1:0] start_hpos;
	sbff_out_t     place_res;
	sbff_out_t     stat_res;

	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign pieces    = in_data.info_byte[7:1];
	assign hbytes_in = {pieces, 2'b10};
	assign cbytes_in = in_data.info_byte[0] ? {pieces, 5'b0} : {1'b0, pieces, 4'b0};

	assign rd_hpos    = ram_rdata[DW-1:CW];
	assign rd_cfill   = ram_rdata[CW-1:0];
	assign start_hpos = PW'(start_ofs_q) + PW'(rsvd_q);

	sbff_bank_ram #(
		.DEPTH(BANK_COUNT),
		.AW   (AW),
		.DW   (DW)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (rd_en),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(ram_rdata)
	);

	sbff_fit #(
		.PW(PW), .CW(CW), .SW(SW), .BANK_BYTES(BANK_BYTES), .ALIGN_MASK(ALIGN_MASK)
	) u_fit_bank (
		.hpos        (rd_hpos),
		.cfill       (rd_cfill),
		.header_bytes(hbytes_q),
		.char_bytes  (cbytes_q),
		.fit         (bank_fit)
	);

	sbff_fit #(
		.PW(PW), .CW(CW), .SW(SW), .BANK_BYTES(BANK_BYTES), .ALIGN_MASK(ALIGN_MASK)
	) u_fit_empty (
		.hpos        ('0),
		.cfill       ('0),
		.header_bytes(hbytes_q),
		.char_bytes  (cbytes_q),
		.fit         (empty_fit)
	);

	always_comb begin
		out_free   = !out_valid_q || !out_stall;
		rd_avail   = (rd_idx_q < banks_open_q);
		found      = (state_q == S_SCAN) && chk_vld_s1 && bank_fit;
		exhaust    = (state_q == S_SCAN) && !chk_vld_s1 && !rd_avail;
		table_full = (banks_open_q == OW'(BANK_COUNT));
		new_ok     = exhaust && !table_full && empty_fit;
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = (in_data.req_type == REQ_START) ? S_RESP : S_SCAN;
				end
			end
			S_SCAN: begin
				if (found || exhaust) begin
					state_d = S_RESP;
				end
			end
			S_RESP: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != S_IDLE);
		start_acc = (state_q == S_IDLE) && in_valid && (in_data.req_type == REQ_START);
		alloc_acc = (state_q == S_IDLE) && in_valid && (in_data.req_type == REQ_ALLOCATE);
		rd_en     = (state_q == S_SCAN) && !found && rd_avail;
		ram_we    = start_acc || found || new_ok;

		sel_hpos  = found ? rd_hpos : '0;
		sel_cfill = found ? rd_cfill : '0;
		sel_j     = found ? chk_idx_s1 : banks_open_q[AW-1:0];
		j_ext     = JW'(sel_j);

		if (start_acc) begin
			ram_waddr = '0;
			ram_wdata = {start_hpos, CW'(0)};
		end else begin
			ram_waddr = sel_j;
			ram_wdata = {PW'(sel_hpos + PW'(hbytes_q)), CW'(sel_cfill + CW'(cbytes_q))};
		end

		place_res               = '0;
		place_res.status        = STAT_PLACED;
		place_res.bank_index    = j_ext[4:0];
		place_res.header_offset = sel_hpos[OFS_W-1:0];
		place_res.header_bytes  = hbytes_q;
		place_res.char_bytes    = cbytes_q;
		place_res.pointer_high  = {1'b1, sel_hpos[13:8]};
		place_res.rom_bank      = j_ext[7:0] + first_rom_q;

		stat_res        = '0;
		stat_res.status = start_acc ? STAT_START_DONE :
			(table_full ? STAT_FULL : STAT_TOO_LARGE);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_ofs_q <= '0;
			rsvd_q      <= '0;
			first_rom_q <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_BANK0_START: start_ofs_q <= cfg_data;
				CFG_BANK0_RSVD:  rsvd_q      <= cfg_data;
				CFG_FIRST_ROM:   first_rom_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			banks_open_q <= '0;
			rd_idx_q     <= '0;
			chk_vld_s1   <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q    <= state_d;
			chk_vld_s1 <= rd_en;
			if (start_acc) begin
				banks_open_q <= OW'(1);
			end else if (new_ok) begin
				banks_open_q <= banks_open_q + OW'(1);
			end
			if (state_q == S_IDLE) begin
				rd_idx_q <= '0;
			end else if (rd_en) begin
				rd_idx_q <= rd_idx_q + OW'(1);
			end
			if (state_q == S_RESP && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		chk_idx_s1 <= rd_idx_q[AW-1:0];
		if (alloc_acc) begin
			hbytes_q <= hbytes_in;
			cbytes_q <= cbytes_in;
		end
		if (found || new_ok) begin
			res_q <= place_res;
		end else if (start_acc || exhaust) begin
			res_q <= stat_res;
		end
		if (state_q == S_RESP && out_free) begin
			out_data_q <= res_q;
		end
	end

	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(ram_we && rd_en))
		else $error("bank memory written during scan read");

	a_open_bound: assert property (@(posedge clk) disable iff (!arst_n)
		banks_open_q <= OW'(BANK_COUNT))
		else $error("open bank count beyond table size");

	a_chk_open: assert property (@(posedge clk) disable iff (!arst_n)
		chk_vld_s1 |-> (OW'(chk_idx_s1) < banks_open_q))
		else $error("checked bank is not open");

	a_resp_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RESP && out_free) |=> (out_valid_q && state_q == S_IDLE))
		else $error("result not moved to output register");

endmodule

// ----- tb/sv/tb_top.sv -----
// Self-checking testbench for the sprite bank first-fit allocator top level.
// Drives start and allocate items plus register writes and checks every result against
// an in-file model of the bank table or a fixed expected result. Depends on sbff_pkg and the allocator RTL.
module tb_top import sbff_pkg::*; ();

	localparam int unsigned BANK_SIZE = 16384;
	localparam int unsigned BANKS = 32;
	localparam int unsigned ALIGN = 31;
	localparam int PHASES = 8;
	localparam int PHASE_ITEMS = 215;
	localparam int HOLD_CYCLES = 400;
	localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

	typedef struct packed {
		logic       kind;
		logic [7:0] info;
		logic [7:0] reps;
		logic       typed;
		sbff_out_t  want;
	} dir_row_t;

	localparam sbff_out_t START_RES =
		'{STAT_START_DONE, 5'd0, 14'd0, 9'd0, 12'd0, 7'd0, 8'd0};
	localparam sbff_out_t FULL_RES =
		'{STAT_FULL, 5'd0, 14'd0, 9'd0, 12'd0, 7'd0, 8'd0};
	localparam sbff_out_t NO_RES = '0;

	localparam int DIR_ROWS = 16;
	localparam dir_row_t DIRECTED [DIR_ROWS] = '{
		'{REQ_ALLOCATE, 8'h00, 8'd1, 1'b1,
			'{STAT_PLACED, 5'd0, 14'd0, 9'd2, 12'd0, 7'h40, 8'd0}},
		'{REQ_ALLOCATE, 8'hff, 8'd1, 1'b1,
			'{STAT_PLACED, 5'd0, 14'd2, 9'd510, 12'd4064, 7'h40, 8'd0}},
		'{REQ_START,    8'h00, 8'd1, 1'b1, START_RES},
		'{REQ_ALLOCATE, 8'h01, 8'd1, 1'b0, NO_RES},
		'{REQ_ALLOCATE, 8'hfe, 8'd1, 1'b0, NO_RES},
		'{REQ_ALLOCATE, 8'h80, 8'd1, 1'b0, NO_RES},
		'{REQ_ALLOCATE, 8'h7f, 8'd1, 1'b0, NO_RES},
		'{REQ_ALLOCATE, 8'haa, 8'd1, 1'b0, NO_RES},
		'{REQ_ALLOCATE, 8'h55, 8'd1, 1'b0, NO_RES},
		'{REQ_START,    8'hff, 8'd1, 1'b1, START_RES},
		'{REQ_ALLOCATE, 8'hff, 8'd100, 1'b0, NO_RES},
		'{REQ_ALLOCATE, 8'hff, 8'd1, 1'b1, FULL_RES},
		'{REQ_ALLOCATE, 8'h02, 8'd1, 1'b0, NO_RES},
		'{REQ_ALLOCATE, 8'h00, 8'd1, 1'b0, NO_RES},
		'{REQ_START,    8'h5a, 8'd1, 1'b1, START_RES},
		'{REQ_ALLOCATE, 8'h03, 8'd1, 1'b0, NO_RES}
	};

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	sbff_in_t             in_data = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	sbff_out_t            out_data;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [OFS_W-1:0]     cfg_data = '0;

	int unsigned hdr_fill [BANKS];
	int unsigned chr_fill [BANKS];
	int unsigned base_of [BANKS];
	int unsigned open_banks = 0;
	int unsigned cfg_start = 0;
	int unsigned cfg_rsvd = 0;
	int unsigned cfg_rom = 0;

	sbff_out_t placement_q [$];
	sbff_out_t oldest_placement;
	int unsigned mismatch_count = 0;
	int unsigned result_count = 0;
	int unsigned idle_pct = 0;
	int unsigned stall_pct = 0;
	int unsigned hold_len = 0;
	int unsigned hold_left = 0;

	sprite_bank_first_fit_allocator_top #(
		.BANK_BYTES(BANK_SIZE),
		.BANK_COUNT(BANKS),
		.ALIGN_MASK(ALIGN)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	initial begin
		#20000000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic bit bank_fits(int unsigned base, int unsigned hfill, int unsigned cfill,
			int unsigned hb, int unsigned cb);
		int unsigned hend;
		hend = (base + hfill + hb + ALIGN) & ~ALIGN;
		return (hend + cfill + cb) <= BANK_SIZE;
	endfunction

	function automatic sbff_out_t place_sprite(sbff_in_t req);
		sbff_out_t res;
		int unsigned pieces, hb, cb, slot, ofs, b;
		bit found;
		res = '0;
		if (req.req_type == REQ_START) begin
			for (b = 0; b < BANKS; b++) begin
				hdr_fill[b] = 0;
				chr_fill[b] = 0;
				base_of[b] = 0;
			end
			base_of[0] = cfg_start;
			hdr_fill[0] = cfg_rsvd;
			open_banks = 1;
			res.status = STAT_START_DONE;
			return res;
		end
		pieces = 32'(req.info_byte[7:1]);
		hb = 2 + 4 * pieces;
		cb = 16 * pieces * (req.info_byte[0] ? 2 : 1);
		found = 1'b0;
		slot = 0;
		for (b = 0; b < open_banks && !found; b++) begin
			if (bank_fits(base_of[b], hdr_fill[b], chr_fill[b], hb, cb)) begin
				slot = b;
				found = 1'b1;
			end
		end
		if (!found) begin
			if (open_banks >= BANKS) begin
				res.status = STAT_FULL;
				return res;
			end
			if (!bank_fits(0, 0, 0, hb, cb)) begin
				res.status = STAT_TOO_LARGE;
				return res;
			end
			slot = open_banks;
			base_of[slot] = 0;
			hdr_fill[slot] = 0;
			chr_fill[slot] = 0;
			open_banks++;
		end
		ofs = (base_of[slot] + hdr_fill[slot]) & 32'h3fff;
		hdr_fill[slot] += hb;
		chr_fill[slot] += cb;
		res.status = STAT_PLACED;
		res.bank_index = slot[4:0];
		res.header_offset = ofs[13:0];
		res.header_bytes = hb[8:0];
		res.char_bytes = cb[11:0];
		res.pointer_high = {1'b1, ofs[13:8]};
		res.rom_bank = 8'(slot + cfg_rom);
		return res;
	endfunction

	task automatic send_request(input logic kind, input logic [7:0] info, input bit typed,
			input sbff_out_t want);
		sbff_in_t item;
		sbff_out_t predicted;
		item.req_type = kind;
		item.info_byte = info;
		@(negedge clk);
		while ($urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		do begin
			@(posedge clk);
		end while (in_stall);
		predicted = place_sprite(item);
		placement_q.push_back(typed ? want : predicted);
	endtask

	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (placement_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [OFS_W-1:0] value);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		case (idx)
			CFG_BANK0_START: cfg_start = 32'(value);
			CFG_BANK0_RSVD:  cfg_rsvd = 32'(value);
			CFG_FIRST_ROM:   cfg_rom = 32'(value[7:0]);
			default: ;
		endcase
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// bursts, most led by a start item; long bursts of big sprites push the table toward full
	task automatic run_bursts(input int quota);
		int sent, len, b;
		bit wide;
		logic kind;
		logic [7:0] info;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 7) != 0) begin
				send_request(REQ_START, 8'($urandom_range(0, 255)), 1'b0, '0);
				sent++;
			end
			wide = ($urandom_range(0, 3) == 0);
			len = wide ? int'($urandom_range(100, 150)) : int'($urandom_range(1, 40));
			for (b = 0; b < len && sent < quota; b++) begin
				kind = REQ_ALLOCATE;
				if ($urandom_range(0, 19) == 0)
					kind = 1'($urandom_range(0, 1));
				info = wide ? 8'($urandom_range(128, 255)) : 8'($urandom_range(0, 255));
				send_request(kind, info, 1'b0, '0);
				sent++;
			end
		end
	endtask

	always @(negedge clk) begin
		if (hold_len != 0) begin
			hold_left = hold_len;
			hold_len = 0;
		end
		if (hold_left != 0) begin
			out_stall <= 1'b1;
			hold_left--;
		end else begin
			out_stall <= ($urandom_range(0, 99) < stall_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			result_count++;
			if (placement_q.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("result %0d arrived with nothing pending", result_count);
			end else begin
				oldest_placement = placement_q.pop_front();
				if (out_data.status !== oldest_placement.status
						|| out_data.bank_index !== oldest_placement.bank_index
						|| out_data.header_offset !== oldest_placement.header_offset
						|| out_data.header_bytes !== oldest_placement.header_bytes
						|| out_data.char_bytes !== oldest_placement.char_bytes
						|| out_data.pointer_high !== oldest_placement.pointer_high
						|| out_data.rom_bank !== oldest_placement.rom_bank) begin
					mismatch_count++;
					if (mismatch_count <= 10) begin
						$display("result %0d expected st=%0d bank=%0d ofs=%0d hdr=%0d chr=%0d ptr=%h rom=%0d",
							result_count, oldest_placement.status,
							oldest_placement.bank_index, oldest_placement.header_offset,
							oldest_placement.header_bytes, oldest_placement.char_bytes,
							oldest_placement.pointer_high, oldest_placement.rom_bank);
						$display("result %0d actual   st=%0d bank=%0d ofs=%0d hdr=%0d chr=%0d ptr=%h rom=%0d",
							result_count, out_data.status, out_data.bank_index,
							out_data.header_offset, out_data.header_bytes,
							out_data.char_bytes, out_data.pointer_high, out_data.rom_bank);
					end
				end
			end
		end
	end

	initial begin
		int r, k, ph;
		logic [OFS_W-1:0] s_ofs, s_rsvd, s_rom;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (r = 0; r < DIR_ROWS; r++)
			for (k = 0; k < int'(DIRECTED[r].reps); k++)
				send_request(DIRECTED[r].kind, DIRECTED[r].info, DIRECTED[r].typed,
					DIRECTED[r].want);
		wait_drained();

		for (ph = 0; ph < PHASES; ph++) begin
			case (ph)
				0: begin s_ofs = 14'h3fff; s_rsvd = 14'h3fff; s_rom = 14'h00ff; end
				1: begin s_ofs = 14'h0000; s_rsvd = 14'h0000; s_rom = 14'h0000; end
				2: begin s_ofs = 14'h3fff; s_rsvd = 14'h0000; s_rom = 14'h3fff; end
				3: begin s_ofs = 14'h0000; s_rsvd = 14'h3fff; s_rom = 14'h0080; end
				default: begin
					s_ofs = 14'($urandom_range(0, 16383));
					s_rsvd = 14'($urandom_range(0, 16383));
					s_rom = 14'($urandom_range(0, 16383));
				end
			endcase
			write_reg(CFG_BANK0_START, s_ofs);
			write_reg(CFG_BANK0_RSVD, s_rsvd);
			write_reg(CFG_FIRST_ROM, s_rom);
			write_reg(CFG_UNUSED, 14'($urandom_range(0, 16383)));
			case (ph % 4)
				0: begin idle_pct = 0; stall_pct = 0; end
				1: begin idle_pct = 76; stall_pct = 0; end
				2: begin idle_pct = 0; stall_pct = 76; end
				default: begin idle_pct = 30; stall_pct = 30; end
			endcase
			if (ph == 0)
				hold_len = HOLD_CYCLES;
			if (ph == 2) begin
				run_bursts(PHASE_ITEMS / 2);
				wait_drained();
				run_bursts(PHASE_ITEMS - PHASE_ITEMS / 2);
			end else begin
				run_bursts(PHASE_ITEMS);
			end
			wait_drained();
		end

		repeat (BANKS + 8) @(posedge clk);
		if (mismatch_count == 0 && placement_q.size() == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
